FILE: design/mrrp_pkg.sv
`default_nettype none

package mrrp_pkg;

    localparam int MAX_FRAME_DEF = 256;
    localparam int FIFO_DEPTH    = 4;

    localparam logic [7:0]  FC_READ_HOLDING = 8'h03;
    localparam logic [7:0]  FC_READ_INPUT   = 8'h04;
    localparam logic [7:0]  FC_WRITE_SINGLE = 8'h06;
    localparam logic [7:0]  FC_WRITE_MULTI  = 8'h10;

    localparam logic [7:0]  FIXED_LENGTH    = 8'd4;
    localparam logic [15:0] CRC_INIT        = 16'hFFFF;
    localparam logic [15:0] CRC_POLY        = 16'hA001;
    localparam logic [7:0]  ADDR_RESET      = 8'd1;

    localparam logic [1:0]  ST_OK         = 2'd0;
    localparam logic [1:0]  ST_BAD_ADDR   = 2'd1;
    localparam logic [1:0]  ST_CRC_ERR    = 2'd2;
    localparam logic [1:0]  ST_TOO_SHORT  = 2'd3;

    localparam logic        KIND_DATA     = 1'b0;
    localparam logic        KIND_STATUS   = 1'b1;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       end_of_frame;
    } in_beat_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic [7:0] data_index;
        logic [1:0] status;
        logic [7:0] function_code;
        logic [7:0] data_length;
        logic       last;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

    function automatic logic [15:0] crc16_feed(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            if (r[0])
            begin
                r = (r >> 1) ^ CRC_POLY;
            end
            else
            begin
                r = r >> 1;
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: design/modbus_rtu_response_parser.sv
// channel  | signals                          | content
// s_axis   | tvalid tready tdata[7:0] tlast   | received byte, end of frame
// m_axis   | tvalid tready tdata tuser tlast  | data byte or frame status
// cfg      | cfg_we cfg_wdata[7:0]            | expected slave address
//
// One byte per cycle while m_axis keeps up; a taken byte waits in the input register
// and its result beats are written into the result queue, which drives m_axis.
// An end-of-frame byte that also releases a data byte yields two result beats,
// so s_axis drops tready while a byte is held and the queue holds more than two beats.
// Reset is asynchronous and takes effect at once; no clearing pass is needed.
// m_axis back-pressure stalls s_axis only through the result queue.
`default_nettype none

module modbus_rtu_response_parser #(
    parameter int MAX_FRAME = mrrp_pkg::MAX_FRAME_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // rx_byte
    input  wire logic        s_axis_tlast,   // end_of_frame
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // data_byte, data_index, status,
                                             // function_code, data_length, zero pad
    output logic [0:0]       m_axis_tuser,   // kind
    output logic             m_axis_tlast,   // last
    input  wire logic        cfg_we,
    input  wire logic [7:0]  cfg_wdata
);
    import mrrp_pkg::*;

    logic [7:0]  addr_reg;
    in_beat_t    in_beat;
    in_beat_t    beat;
    logic        beat_valid;
    logic        room_for_two;
    logic        take;
    push_t       push;
    result_t     out_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg <= ADDR_RESET;
        end
        else if (cfg_we)
        begin
            addr_reg <= cfg_wdata;
        end
    end

    assign in_beat.rx_byte      = s_axis_tdata;
    assign in_beat.end_of_frame = s_axis_tlast;
    assign take = beat_valid && room_for_two;

    mrrp_in_reg u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_beat    (in_beat),
        .take       (take),
        .beat_valid (beat_valid),
        .beat       (beat)
    );

    mrrp_parse #(
        .MAX_FRAME (MAX_FRAME)
    ) u_parse (
        .clk           (clk),
        .rst_n         (rst_n),
        .slave_address (addr_reg),
        .take          (take),
        .beat          (beat),
        .push          (push)
    );

    mrrp_out_fifo u_fifo (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .room_for_two (room_for_two),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_res      (out_res)
    );

    assign m_axis_tdata = {6'b0, out_res.data_length, out_res.function_code,
                           out_res.status, out_res.data_index, out_res.data_byte};
    assign m_axis_tuser = out_res.kind;
    assign m_axis_tlast = out_res.last;

endmodule

`default_nettype wire

FILE: design/mrrp_in_reg.sv
`default_nettype none

module mrrp_in_reg (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire mrrp_pkg::in_beat_t in_beat,
    input  wire logic              take,
    output logic                   beat_valid,
    output mrrp_pkg::in_beat_t     beat
);
    import mrrp_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_beat_t beat_reg;

    assign in_ready   = !valid_reg || take;
    assign beat_valid = valid_reg;
    assign beat       = beat_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            beat_reg <= in_beat;
        end
    end

endmodule

`default_nettype wire

FILE: design/mrrp_parse.sv
`default_nettype none

module mrrp_parse #(
    parameter int MAX_FRAME = mrrp_pkg::MAX_FRAME_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [7:0]         slave_address,
    input  wire logic               take,
    input  wire mrrp_pkg::in_beat_t beat,
    output mrrp_pkg::push_t         push
);
    import mrrp_pkg::*;

    localparam int PW = $clog2(MAX_FRAME + 1);
    localparam int CW = (PW > 8) ? PW : 8;

    logic [15:0]   crc_reg;
    logic [15:0]   crc_next;
    logic [PW-1:0] pos_reg;
    logic [PW-1:0] pos_next;
    logic [7:0]    d0_reg;
    logic [7:0]    d0_next;
    logic [7:0]    d1_reg;
    logic [7:0]    d1_next;
    logic [7:0]    fc_reg;
    logic [7:0]    fc_next;
    logic [7:0]    len_reg;
    logic [7:0]    len_next;
    logic          match_reg;
    logic          match_next;

    logic [7:0]    fc_cur;
    logic [7:0]    len_cur;
    logic          match_cur;
    logic [15:0]   crc_cur;
    logic          fc_is_read;
    logic [PW-1:0] start;
    logic [PW-1:0] q;
    logic [PW-1:0] idx;
    logic          emit;
    logic [1:0]    st;
    result_t       data_res;
    result_t       stat_res;

    always_comb
    begin
        match_cur = (pos_reg == '0) ? (beat.rx_byte == slave_address) : match_reg;
        fc_cur    = (pos_reg == PW'(1)) ? beat.rx_byte : fc_reg;
        len_cur   = len_reg;
        if (pos_reg == PW'(1))
        begin
            len_cur = (beat.rx_byte == FC_WRITE_SINGLE || beat.rx_byte == FC_WRITE_MULTI)
                      ? FIXED_LENGTH : 8'd0;
        end
        else if (pos_reg == PW'(2) && (fc_reg == FC_READ_HOLDING || fc_reg == FC_READ_INPUT))
        begin
            len_cur = beat.rx_byte;
        end

        fc_is_read = (fc_reg == FC_READ_HOLDING || fc_reg == FC_READ_INPUT);
        start      = fc_is_read ? PW'(3) : PW'(2);
        q          = pos_reg - PW'(2);
        idx        = q - start;
        crc_cur    = (pos_reg >= PW'(2)) ? crc16_feed(crc_reg, d1_reg) : crc_reg;
        emit       = take && (pos_reg >= PW'(2)) && (pos_reg < PW'(MAX_FRAME))
                     && (q >= start) && (CW'(idx) < CW'(len_cur));

        if (!match_cur)
        begin
            st = ST_BAD_ADDR;
        end
        else if (pos_reg < PW'(3))
        begin
            st = ST_TOO_SHORT;
        end
        else if ({beat.rx_byte, d0_reg} == crc_cur)
        begin
            st = ST_OK;
        end
        else
        begin
            st = ST_CRC_ERR;
        end

        data_res               = '0;
        data_res.kind          = KIND_DATA;
        data_res.data_byte     = d1_reg;
        data_res.data_index    = 8'(idx);
        data_res.function_code = fc_cur;
        data_res.data_length   = len_cur;

        stat_res               = '0;
        stat_res.kind          = KIND_STATUS;
        stat_res.status        = st;
        stat_res.function_code = fc_cur;
        stat_res.data_length   = len_cur;
        stat_res.last          = 1'b1;
    end

    always_comb
    begin
        push.count  = {1'b0, emit} + {1'b0, take && beat.end_of_frame};
        push.first  = emit ? data_res : stat_res;
        push.second = stat_res;
    end

    always_comb
    begin
        crc_next   = crc_reg;
        pos_next   = pos_reg;
        d0_next    = d0_reg;
        d1_next    = d1_reg;
        fc_next    = fc_reg;
        len_next   = len_reg;
        match_next = match_reg;
        if (take)
        begin
            if (beat.end_of_frame)
            begin
                crc_next   = CRC_INIT;
                pos_next   = '0;
                d0_next    = '0;
                d1_next    = '0;
                fc_next    = '0;
                len_next   = '0;
                match_next = 1'b0;
            end
            else
            begin
                crc_next   = crc_cur;
                pos_next   = (pos_reg == PW'(MAX_FRAME)) ? pos_reg : pos_reg + PW'(1);
                d0_next    = beat.rx_byte;
                d1_next    = d0_reg;
                fc_next    = fc_cur;
                len_next   = len_cur;
                match_next = match_cur;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg   <= CRC_INIT;
            pos_reg   <= '0;
            d0_reg    <= '0;
            d1_reg    <= '0;
            fc_reg    <= '0;
            len_reg   <= '0;
            match_reg <= 1'b0;
        end
        else
        begin
            crc_reg   <= crc_next;
            pos_reg   <= pos_next;
            d0_reg    <= d0_next;
            d1_reg    <= d1_next;
            fc_reg    <= fc_next;
            len_reg   <= len_next;
            match_reg <= match_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/mrrp_out_fifo.sv
`default_nettype none

module mrrp_out_fifo (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire mrrp_pkg::push_t push,
    output logic                 room_for_two,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output mrrp_pkg::result_t    out_res
);
    import mrrp_pkg::*;

    localparam int AW = $clog2(FIFO_DEPTH);
    localparam int NW = $clog2(FIFO_DEPTH + 1);

    result_t       mem [FIFO_DEPTH];
    logic [AW-1:0] wp_reg;
    logic [AW-1:0] wp_next;
    logic [AW-1:0] rp_reg;
    logic [AW-1:0] rp_next;
    logic [NW-1:0] cnt_reg;
    logic [NW-1:0] cnt_next;
    logic          pop;

    assign out_valid    = (cnt_reg != '0);
    assign out_res      = mem[rp_reg];
    assign room_for_two = (cnt_reg <= NW'(FIFO_DEPTH - 2));
    assign pop          = out_valid && out_ready;

    always_comb
    begin
        wp_next  = wp_reg + AW'(push.count);
        rp_next  = pop ? rp_reg + AW'(1) : rp_reg;
        cnt_next = cnt_reg + NW'(push.count) - NW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem[wp_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem[wp_reg + AW'(1)] <= push.second;
        end
    end

endmodule

`default_nettype wire

FILE: design/mrrp_checker.sv
`default_nettype none

module mrrp_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [39:0] m_axis_tdata,
    input  wire logic [0:0]  m_axis_tuser,
    input  wire logic        m_axis_tlast
);
    import mrrp_pkg::*;

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    a_last_is_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser[0] == KIND_STATUS)))
        else $error("tlast does not match a status beat");

    a_data_no_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] == KIND_DATA |-> m_axis_tdata[17:16] == ST_OK)
        else $error("data beat carries a status");

    a_status_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] == KIND_STATUS |-> m_axis_tdata[15:0] == 16'h0000)
        else $error("status beat carries data");

endmodule

bind modbus_rtu_response_parser mrrp_checker u_mrrp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

FILE: verif/tb_modbus_rtu_response_parser.sv
`timescale 1ns / 100ps

module tb_modbus_rtu_response_parser;

    import mrrp_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int SETTLE_TICKS = 4;
    localparam int FRAME_CAP    = MAX_FRAME_DEF;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic [7:0]  s_axis_tdata  = 8'h00;
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tready = 1'b0;
    logic        cfg_we        = 1'b0;
    logic [7:0]  cfg_wdata     = 8'h00;
    wire         s_axis_tready;
    wire         m_axis_tvalid;
    wire  [39:0] m_axis_tdata;
    wire  [0:0]  m_axis_tuser;
    wire         m_axis_tlast;

    // frame tracker state
    logic [7:0]  slave_addr_model;
    logic [15:0] crc_acc;
    int          rx_pos;
    logic [7:0]  held_bytes [2];
    logic [7:0]  fn_model;
    logic [7:0]  len_model;
    logic        addr_ok;

    // result side as seen just before the next rising edge
    logic        mon_take      = 1'b0;
    logic [39:0] mon_tdata     = '0;
    logic [0:0]  mon_tuser     = '0;
    logic        mon_tlast     = 1'b0;

    result_t     expected_results [$];
    logic [7:0]  frame_bytes [$];
    int          error_count   = 0;
    int          cycle_count   = 0;
    int          bytes_sent    = 0;
    int          ready_stall   = 0;
    bit          send_idle_en  = 1'b0;
    bit          recv_idle_en  = 1'b0;

    modbus_rtu_response_parser uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [15:0] modbus_crc_next(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        repeat (8)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic bit is_read_code(input logic [7:0] fc);
        return (fc == FC_READ_HOLDING) || (fc == FC_READ_INPUT);
    endfunction

    task automatic clear_frame_state();
        crc_acc       = CRC_INIT;
        rx_pos        = 0;
        held_bytes[0] = 8'h00;
        held_bytes[1] = 8'h00;
        fn_model      = 8'h00;
        len_model     = 8'h00;
        addr_ok       = 1'b0;
    endtask

    // Updates the frame tracker with one accepted byte and queues the beats it yields.
    task automatic parse_rx_byte(input logic [7:0] rx, input logic eof);
        int          p;
        int          q;
        int          s;
        logic [7:0]  leaving;
        logic [15:0] got;
        result_t     r;
        p = rx_pos;
        if (p == 0)
        begin
            addr_ok = (rx == slave_addr_model);
        end
        else if (p == 1)
        begin
            fn_model  = rx;
            len_model = (rx == FC_WRITE_SINGLE || rx == FC_WRITE_MULTI) ? FIXED_LENGTH : 8'd0;
        end
        else if (p == 2 && is_read_code(fn_model))
        begin
            len_model = rx;
        end

        if (p >= 2)
        begin
            leaving = held_bytes[1];
            crc_acc = modbus_crc_next(crc_acc, leaving);
            q = p - 2;
            s = is_read_code(fn_model) ? 3 : 2;
            if (p < FRAME_CAP && q >= s && (q - s) < int'(len_model))
            begin
                r               = '0;
                r.kind          = KIND_DATA;
                r.data_byte     = leaving;
                r.data_index    = 8'(q - s);
                r.status        = ST_OK;
                r.function_code = fn_model;
                r.data_length   = len_model;
                r.last          = 1'b0;
                expected_results.push_back(r);
            end
        end

        if (eof)
        begin
            r      = '0;
            r.kind = KIND_STATUS;
            if (!addr_ok)
            begin
                r.status = ST_BAD_ADDR;
            end
            else if (p < 3)
            begin
                r.status = ST_TOO_SHORT;
            end
            else
            begin
                got      = {rx, held_bytes[0]};
                r.status = (got == crc_acc) ? ST_OK : ST_CRC_ERR;
            end
            r.function_code = fn_model;
            r.data_length   = len_model;
            r.last          = 1'b1;
            expected_results.push_back(r);
            clear_frame_state();
        end
        else
        begin
            held_bytes[1] = held_bytes[0];
            held_bytes[0] = rx;
            if (rx_pos < FRAME_CAP)
            begin
                rx_pos++;
            end
        end
    endtask

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    always @(negedge clk)
    begin
        mon_take  = (m_axis_tvalid === 1'b1) && (m_axis_tready === 1'b1);
        mon_tdata = m_axis_tdata;
        mon_tuser = m_axis_tuser;
        mon_tlast = m_axis_tlast;
    end

    always @(posedge clk)
    begin : result_monitor
        result_t exp_r;
        if (mon_take)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result beat: tdata %h tuser %b tlast %b",
                       mon_tdata, mon_tuser, mon_tlast);
                error_count++;
            end
            else
            begin
                exp_r = expected_results.pop_front();
                check_field("kind", exp_r.kind, mon_tuser[0]);
                check_field("data_byte", exp_r.data_byte, mon_tdata[7:0]);
                check_field("data_index", exp_r.data_index, mon_tdata[15:8]);
                check_field("status", exp_r.status, mon_tdata[17:16]);
                check_field("function_code", exp_r.function_code, mon_tdata[25:18]);
                check_field("data_length", exp_r.data_length, mon_tdata[33:26]);
                check_field("last", exp_r.last, mon_tlast);
            end
            ready_stall = recv_idle_en ? $urandom_range(0, 3) : 0;
        end
        else if (ready_stall > 0)
        begin
            ready_stall--;
        end
        m_axis_tready <= (ready_stall == 0);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eof);
        int gap;
        gap = send_idle_en ? $urandom_range(0, 3) : 0;
        repeat (gap)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eof;
        @(negedge clk);
        while (!s_axis_tready)
        begin
            @(negedge clk);
        end
        @(posedge clk);
        parse_rx_byte(b, eof);
    endtask

    task automatic send_frame();
        int n;
        n = frame_bytes.size();
        for (int i = 0; i < n; i++)
        begin
            send_byte(frame_bytes[i], i == n - 1);
        end
        bytes_sent += n;
        frame_bytes.delete();
    endtask

    task automatic add_crc(input bit corrupt);
        logic [15:0] c;
        c = CRC_INIT;
        foreach (frame_bytes[i])
        begin
            c = modbus_crc_next(c, frame_bytes[i]);
        end
        if (corrupt)
        begin
            c = c ^ (16'd1 << $urandom_range(0, 15));
        end
        frame_bytes.push_back(c[7:0]);
        frame_bytes.push_back(c[15:8]);
    endtask

    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    task automatic write_slave_address(input logic [7:0] v);
        wait_results_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        slave_addr_model = v;
        cfg_we <= 1'b0;
    endtask

    task automatic build_random_response();
        int         sel;
        int         cnt;
        int         n_data;
        int         keep;
        logic [7:0] fc;
        frame_bytes.delete();
        frame_bytes.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom) : slave_addr_model);
        sel = $urandom_range(0, 9);
        case (sel)
            0, 1, 2: fc = FC_READ_HOLDING;
            3, 4:    fc = FC_READ_INPUT;
            5, 6:    fc = FC_WRITE_SINGLE;
            7:       fc = FC_WRITE_MULTI;
            default: fc = 8'($urandom);
        endcase
        frame_bytes.push_back(fc);
        if (is_read_code(fc))
        begin
            cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 8);
            frame_bytes.push_back(8'(cnt));
            n_data = (cnt > 16) ? $urandom_range(0, 16) : cnt;
            if ($urandom_range(0, 4) == 0)
            begin
                n_data = $urandom_range(0, 16);
            end
        end
        else if (fc == FC_WRITE_SINGLE || fc == FC_WRITE_MULTI)
        begin
            n_data = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 7) : 4;
        end
        else
        begin
            n_data = $urandom_range(0, 6);
        end
        repeat (n_data)
        begin
            frame_bytes.push_back(8'($urandom));
        end
        add_crc($urandom_range(0, 7) == 0);
        // broken frame: cut anywhere
        if ($urandom_range(0, 11) == 0)
        begin
            keep = $urandom_range(1, frame_bytes.size());
            while (frame_bytes.size() > keep)
            begin
                void'(frame_bytes.pop_back());
            end
        end
    endtask

    task automatic build_noise_frame();
        int n;
        n = $urandom_range(1, 12);
        frame_bytes.delete();
        frame_bytes.push_back($urandom_range(0, 1) ? slave_addr_model : 8'($urandom));
        repeat (n - 1)
        begin
            frame_bytes.push_back(8'($urandom));
        end
    endtask

    task automatic test_directed_frames();
        send_idle_en = 1'b0;
        recv_idle_en = 1'b0;
        // lone address byte
        frame_bytes.push_back(ADDR_RESET);
        send_frame();
        // wrong address wins over too short
        frame_bytes.push_back(8'hFF);
        frame_bytes.push_back(FC_READ_HOLDING);
        send_frame();
        // read holding, two data bytes, good crc
        frame_bytes.push_back(ADDR_RESET);
        frame_bytes.push_back(FC_READ_HOLDING);
        frame_bytes.push_back(8'd2);
        frame_bytes.push_back(8'h00);
        frame_bytes.push_back(8'hFF);
        add_crc(1'b0);
        send_frame();
        // byte count runs past the crc
        frame_bytes.push_back(ADDR_RESET);
        frame_bytes.push_back(FC_READ_INPUT);
        frame_bytes.push_back(8'hFF);
        frame_bytes.push_back(8'hA5);
        add_crc(1'b0);
        send_frame();
        // write single echo, bad crc
        frame_bytes.push_back(ADDR_RESET);
        frame_bytes.push_back(FC_WRITE_SINGLE);
        frame_bytes.push_back(8'h00);
        frame_bytes.push_back(8'h01);
        frame_bytes.push_back(8'hFF);
        frame_bytes.push_back(8'h00);
        add_crc(1'b1);
        send_frame();
        wait_results_drained();
    endtask

    task automatic test_random_responses(input int n_bytes);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                send_idle_en = !send_idle_en;
            end
            if ($urandom_range(0, 7) == 0)
            begin
                recv_idle_en = !recv_idle_en;
            end
            if ($urandom_range(0, 29) == 0)
            begin
                wait_results_drained();
            end
            if ($urandom_range(0, 9) == 0)
            begin
                build_noise_frame();
            end
            else
            begin
                build_random_response();
            end
            send_frame();
        end
        wait_results_drained();
    endtask

    task automatic test_address_extremes();
        write_slave_address(8'h00);
        test_random_responses(100);
        write_slave_address(8'hFF);
        test_random_responses(100);
    endtask

    task automatic test_random_addresses();
        repeat (3)
        begin
            write_slave_address(8'($urandom));
            test_random_responses(70);
        end
    endtask

    // frames past MAX_FRAME: data stops, crc and status keep going
    task automatic test_long_frames();
        int lens [2];
        lens[0] = 270;
        lens[1] = 300;
        write_slave_address(ADDR_RESET);
        for (int k = 0; k < 2; k++)
        begin
            frame_bytes.push_back(ADDR_RESET);
            frame_bytes.push_back(FC_READ_HOLDING);
            frame_bytes.push_back(8'hFF);
            while (frame_bytes.size() < lens[k] - 2)
            begin
                frame_bytes.push_back(8'($urandom));
            end
            add_crc(k == 1);
            send_frame();
        end
        wait_results_drained();
    endtask

    initial
    begin
        slave_addr_model = ADDR_RESET;
        clear_frame_state();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_frames();
        test_random_responses(200);
        test_address_extremes();
        test_random_addresses();
        test_long_frames();

        wait_results_drained();
        if (error_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

FILE: modbus_rtu_response_parser.f
design/mrrp_pkg.sv
design/mrrp_in_reg.sv
design/mrrp_parse.sv
design/mrrp_out_fifo.sv
design/modbus_rtu_response_parser.sv
design/mrrp_checker.sv
verif/tb_modbus_rtu_response_parser.sv
